// ----- hdl/nsfc_pkg.sv -----
// shared types, character codes and helpers for the nmea sentence framer
`default_nettype none

package nsfc_pkg;

  // sentence store depth in bytes
  localparam int unsigned StoreDepth = 128;
  localparam int unsigned CountW     = 8;
  localparam int unsigned IndexW     = 7;

  // character codes
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTilde  = 8'h7E;

  // full store count
  localparam logic [CountW-1:0] CountFull = CountW'(StoreDepth);

  // per-byte status reported with each result
  typedef enum logic [1:0] {
    ST_START   = 2'd0,
    ST_STORED  = 2'd1,
    ST_DONE    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  // checksum field tracking
  typedef enum logic [3:0] {
    PH_BEFORE = 4'b0001,
    PH_DIGITS = 4'b0010,
    PH_ENDED  = 4'b0100,
    PH_OVER   = 4'b1000
  } phase_e;

  // framer state carried from byte to byte
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [7:0]        last;
    logic [7:0]        xsum;
    phase_e            phase;
    logic [7:0]        rx_sum;
    logic [1:0]        digits;
  } frame_state_t;

  // result of one byte
  typedef struct packed {
    status_e           status;
    logic [7:0]        stored_byte;
    logic [IndexW-1:0] store_index;
    logic [CountW-1:0] length;
    logic              ok;
    logic [7:0]        xsum;
  } frame_result_t;

  localparam frame_state_t StateClear = '{
    count:  '0,
    last:   '0,
    xsum:   '0,
    phase:  PH_BEFORE,
    rx_sum: '0,
    digits: '0
  };

  // hex digit decode: bit 4 flags a valid digit, bits 3:0 its value
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/nsfc_step.sv -----
// next-state and result logic for one received byte
`default_nettype none

module nsfc_step (
  input  wire logic [7:0]            rx_byte_i,
  input  wire nsfc_pkg::frame_state_t cur_i,
  output nsfc_pkg::frame_state_t     nxt_o,
  output nsfc_pkg::frame_result_t    res_o
);
  import nsfc_pkg::*;

  logic       printable;
  logic [4:0] hex;
  logic       done;

  assign printable = (rx_byte_i >= ChSpace) && (rx_byte_i <= ChTilde);
  assign hex       = hex_decode(rx_byte_i);

  // byte classification, store and checksum tracking
  always_comb begin
    nxt_o             = cur_i;
    res_o.status      = ST_IGNORED;
    res_o.stored_byte = '0;
    res_o.store_index = '0;
    res_o.length      = '0;
    res_o.ok          = 1'b0;
    done              = 1'b0;

    priority if (rx_byte_i == ChDollar) begin
      nxt_o             = StateClear;
      nxt_o.count       = CountW'(1);
      nxt_o.last        = rx_byte_i;
      res_o.status      = ST_START;
      res_o.stored_byte = rx_byte_i;
    end else if ((printable && cur_i.count != '0) || rx_byte_i == ChCr) begin
      if (cur_i.count < CountFull) begin
        res_o.status      = ST_STORED;
        res_o.stored_byte = rx_byte_i;
        res_o.store_index = cur_i.count[IndexW-1:0];
        nxt_o.count       = cur_i.count + CountW'(1);
        nxt_o.last        = rx_byte_i;
        // checksum field tracking, only inside an open sentence
        if (cur_i.count != '0) begin
          if (rx_byte_i == ChCr) begin
            if (cur_i.phase == PH_DIGITS) nxt_o.phase = PH_ENDED;
          end else if (cur_i.phase == PH_BEFORE) begin
            if (rx_byte_i == ChStar) nxt_o.phase = PH_DIGITS;
            else nxt_o.xsum = cur_i.xsum ^ rx_byte_i;
          end else if (cur_i.phase == PH_DIGITS) begin
            if (!hex[4]) begin
              nxt_o.phase = PH_ENDED;
            end else if (cur_i.digits < 2'd2) begin
              nxt_o.rx_sum = {cur_i.rx_sum[3:0], hex[3:0]};
              nxt_o.digits = cur_i.digits + 2'd1;
            end else begin
              nxt_o.phase = PH_OVER;
            end
          end
        end
      end
    end else if (rx_byte_i == ChLf && cur_i.count > CountW'(1) && cur_i.last == ChCr) begin
      done         = 1'b1;
      res_o.status = ST_DONE;
      res_o.length = cur_i.count - CountW'(1);
      res_o.ok     = (cur_i.phase == PH_DIGITS || cur_i.phase == PH_ENDED) &&
                     (cur_i.digits != 2'd0) && (cur_i.rx_sum == cur_i.xsum);
      nxt_o        = StateClear;
    end else begin
      // ignored byte, state and result keep their defaults
    end

    // running xor after this byte, final value on completion
    res_o.xsum = done ? cur_i.xsum : nxt_o.xsum;
  end

endmodule

`default_nettype wire

// ----- hdl/nmea_sentence_framer_checksum.sv -----
// top level of the nmea sentence framer with xor checksum check
// path: accepted byte in the input register, step logic, then result register
// throughput: one byte per cycle unless the output stalls, one result per byte,
//   set by the single register-to-register step of the framer state
// reset: rst_ni clears the framer state and both stage valids, no sentence open
`default_nettype none

module nmea_sentence_framer_checksum (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      status_o,
  output logic [7:0]      stored_byte_o,
  output logic [6:0]      store_index_o,
  output logic [7:0]      sentence_length_o,
  output logic            checksum_ok_o,
  output logic [7:0]      computed_checksum_o
);
  import nsfc_pkg::*;

  logic          in_valid_q;
  logic [7:0]    byte_q;
  frame_state_t  state_q, state_d;
  frame_result_t res_d, res_q;
  logic          out_valid_q;
  logic          out_ready;
  logic          advance;

  // stage handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) byte_q <= rx_byte_i;
  end

  // per-byte framing logic
  nsfc_step u_step (
    .rx_byte_i (byte_q),
    .cur_i     (state_q),
    .nxt_o     (state_d),
    .res_o     (res_d)
  );

  // framer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = res_q.status;
  assign stored_byte_o       = res_q.stored_byte;
  assign store_index_o       = res_q.store_index;
  assign sentence_length_o   = res_q.length;
  assign checksum_ok_o       = res_q.ok;
  assign computed_checksum_o = res_q.xsum;

`ifndef SYNTHESIS
  // a completed sentence leaves no sentence open
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.status == ST_DONE |=> state_q.count == '0)
    else $error("state not cleared after sentence completion");

  // the store never goes past its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.count <= CountFull)
    else $error("store count beyond depth");

  // input side only stalls while holding a byte
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("stall without held byte");

  // a sentence start always reports the dollar at index zero
  a_start_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_START |->
      stored_byte_o == ChDollar && store_index_o == '0)
    else $error("malformed sentence start result");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the nmea sentence framer with xor checksum check
`timescale 1ns / 100ps

module testbench;
  import nsfc_pkg::*;

  localparam int unsigned ItemsPerRound = 230;
  localparam int unsigned RoundCount    = 8;
  localparam int unsigned QuietLimit    = 3000;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned ReportLimit   = 10;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // framing predictor and queue of expected per-byte results
  class framer_scoreboard;
    frame_result_t pending_results[$];
    int unsigned   mismatch_count;
    logic [7:0]    count;
    logic [7:0]    last;
    logic [7:0]    xsum;
    phase_e        phase;
    logic [7:0]    rx_sum;
    logic [1:0]    digits;

    function new();
      mismatch_count = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      count  = '0;
      last   = '0;
      xsum   = '0;
      phase  = PH_BEFORE;
      rx_sum = '0;
      digits = '0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // value of an ascii hex digit, -1 for anything else
    function int hex_nibble(logic [7:0] b);
      if (b inside {[8'h30:8'h39]}) return int'(b) - 'h30;
      if (b inside {[8'h41:8'h46]}) return int'(b) - 'h41 + 10;
      if (b inside {[8'h61:8'h66]}) return int'(b) - 'h61 + 10;
      return -1;
    endfunction

    // xor over the body, then the hex digits after the star
    function void update_checksum(logic [7:0] b);
      int d;
      d = 0;
      if (b == ChCr) begin
        if (phase == PH_DIGITS) phase = PH_ENDED;
        return;
      end
      if (phase == PH_BEFORE) begin
        if (b == ChStar) phase = PH_DIGITS;
        else xsum = xsum ^ b;
        return;
      end
      if (phase != PH_DIGITS) return;
      d = hex_nibble(b);
      if (d < 0) begin
        phase = PH_ENDED;
      end else if (digits < 2) begin
        rx_sum = {rx_sum[3:0], 4'(d)};
        digits = digits + 2'd1;
      end else begin
        phase = PH_OVER;
      end
    endfunction

    // accepted byte: advance the framer and queue its result
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      r = '0;
      r.status = ST_IGNORED;
      if (b == ChDollar) begin
        clear_frame();
        count = 8'd1;
        last = b;
        r.status = ST_START;
        r.stored_byte = b;
      end else if ((b >= ChSpace && b <= ChTilde && count > 0) || b == ChCr) begin
        if (count < StoreDepth) begin
          r.store_index = count[6:0];
          r.stored_byte = b;
          r.status = ST_STORED;
          if (count >= 1) update_checksum(b);
          count = count + 8'd1;
          last = b;
        end
      end else if (b == ChLf && count > 1 && last == ChCr) begin
        r.status = ST_DONE;
        r.length = count - 8'd1;
        r.ok = ((phase == PH_DIGITS || phase == PH_ENDED) && digits >= 1 &&
                rx_sum == xsum);
      end
      r.xsum = xsum;
      if (r.status == ST_DONE) clear_frame();
      pending_results.push_back(r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(frame_result_t act);
      frame_result_t exp;
      if (pending_results.size() == 0) begin
        if (mismatch_count < ReportLimit)
          $display("unexpected result: status %0d byte %h index %0d len %0d ok %b xor %h",
                   act.status, act.stored_byte, act.store_index, act.length,
                   act.ok, act.xsum);
        mismatch_count++;
        return;
      end
      exp = pending_results.pop_front();
      if (exp.status !== act.status || exp.stored_byte !== act.stored_byte ||
          exp.store_index !== act.store_index || exp.length !== act.length ||
          exp.ok !== act.ok || exp.xsum !== act.xsum) begin
        if (mismatch_count < ReportLimit) begin
          $display("mismatch expected: status %0d byte %h index %0d len %0d ok %b xor %h",
                   exp.status, exp.stored_byte, exp.store_index, exp.length,
                   exp.ok, exp.xsum);
          $display("         actual:   status %0d byte %h index %0d len %0d ok %b xor %h",
                   act.status, act.stored_byte, act.store_index, act.length,
                   act.ok, act.xsum);
        end
        mismatch_count++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [7:0] stored_byte_o;
  logic [6:0] store_index_o;
  logic [7:0] sentence_length_o;
  logic       checksum_ok_o;
  logic [7:0] computed_checksum_o;

  framer_scoreboard sb = new();
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      hold_left = 0;
  int unsigned      items_sent = 0;
  int unsigned      quiet_cycles = 0;

  nmea_sentence_framer_checksum u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .stored_byte_o      (stored_byte_o),
    .store_index_o      (store_index_o),
    .sentence_length_o  (sentence_length_o),
    .checksum_ok_o      (checksum_ok_o),
    .computed_checksum_o(computed_checksum_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // receiver stalls, with a counted long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= roll(stall_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    frame_result_t act;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      act.status      = status_e'(status_o);
      act.stored_byte = stored_byte_o;
      act.store_index = store_index_o;
      act.length      = sentence_length_o;
      act.ok          = checksum_ok_o;
      act.xsum        = computed_checksum_o;
      sb.check_result(act);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("nmea_sentence_framer_checksum test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one byte, with random idle cycles, until the transaction completes
  task automatic send_byte(input logic [7:0] b);
    while (roll(send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b);
    items_sent++;
  endtask

  // drop valid and wait until every expected result is in
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] printable_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(32, 126)); while (ch == ChDollar || ch == ChStar);
    return ch;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // one sentence with random body and mostly well-formed checksum field
  task automatic send_sentence();
    int unsigned body_len;
    int unsigned tail_kind;
    logic [7:0]  sum;
    logic [7:0]  claim;
    bit          upper;
    if (roll(4)) body_len = $urandom_range(120, 140);
    else body_len = $urandom_range(0, 24);
    upper = $urandom_range(0, 1);
    sum = '0;
    send_byte(ChDollar);
    for (int i = 0; i < body_len; i++) begin
      claim = printable_byte();
      sum ^= claim;
      send_byte(claim);
      if (roll(1)) send_byte(8'($urandom_range(0, 255)));
    end
    tail_kind = $urandom_range(0, 99);
    claim = (tail_kind < 70 || tail_kind >= 88) ? sum : 8'($urandom_range(0, 255));
    // no star at all for the lowest kinds
    if (tail_kind >= 5) begin
      send_byte(ChStar);
      if (tail_kind < 84) begin
        send_byte(hex_char(claim[7:4], upper));
        send_byte(hex_char(claim[3:0], upper));
      end else if (tail_kind < 88) begin
        send_byte(hex_char(claim[3:0], upper));
      end else if (tail_kind < 90) begin
        // star with no digits
      end else if (tail_kind < 95) begin
        send_byte(hex_char(claim[7:4], upper));
        send_byte(hex_char(claim[3:0], upper));
        send_byte(hex_char(4'($urandom_range(0, 15)), upper));
      end else begin
        // a non-hex byte ends the digits early
        send_byte(hex_char(claim[7:4], upper));
        send_byte(8'h5A);
        send_byte(hex_char(claim[3:0], upper));
      end
    end
    if (roll(96)) send_byte(ChCr);
    if (roll(96)) send_byte(ChLf);
  endtask

  task automatic set_idling(idle_mode_e mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 62 : (mode == IDLE_BOTH) ? 11 : 0;
    stall_pct     = (mode == IDLE_RECEIVER) ? 62 : (mode == IDLE_BOTH) ? 11 : 0;
  endtask

  // directed bytes: extremes, stray cr and lf, matching, empty and starless sentences
  task automatic run_directed();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'hFF, 8'h7F, ChLf, 8'h41, ChCr, ChLf,
            ChDollar, ChSpace, ChTilde, ChStar, 8'h35, 8'h65, ChCr, ChLf,
            ChDollar, ChStar, ChCr, ChLf,
            ChDollar, 8'h41, ChLf, ChCr, ChLf};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // main sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(IDLE_NONE);
    run_directed();
    for (int round = 0; round < RoundCount; round++) begin
      set_idling(idle_mode_e'(round % 4));
      if (round == 4) hold_left = LongHold;
      while (items_sent < (round + 1) * ItemsPerRound) begin
        if (roll(12)) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_sentence();
        end
      end
      drain();
    end
    repeat (10) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("nmea_sentence_framer_checksum test passed");
    end else begin
      $display("nmea_sentence_framer_checksum test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/nsfc_pkg.sv
hdl/nsfc_step.sv
hdl/nmea_sentence_framer_checksum.sv
tb/sv/testbench.sv
